### rtl/leb_pkg.sv
`default_nettype none

package leb_pkg;

  // Default line capacity in characters.
  localparam int MAX_LEN_DEF = 64;

  // Width of the length, cursor and character result fields.
  localparam int FIELD_W = 7;

  // Reset value of the capacity register.
  localparam logic [6:0] MAX_CHARS_RST = 7'd64;

  // Printable ASCII range accepted by the type command.
  localparam logic [7:0] CHAR_LOW  = 8'd32;
  localparam logic [7:0] CHAR_HIGH = 8'd126;

  // Keystroke command codes on the input channel.
  localparam logic [3:0] CMD_TYPE  = 4'd0;
  localparam logic [3:0] CMD_BKSP  = 4'd1;
  localparam logic [3:0] CMD_DEL   = 4'd2;
  localparam logic [3:0] CMD_LEFT  = 4'd3;
  localparam logic [3:0] CMD_RIGHT = 4'd4;
  localparam logic [3:0] CMD_HOME  = 4'd5;
  localparam logic [3:0] CMD_END   = 4'd6;
  localparam logic [3:0] CMD_CLEAR = 4'd7;
  localparam logic [3:0] CMD_READ  = 4'd8;

  // Classified operations passed from the front end to the editing engine.
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_INSERT = 4'd1;
  localparam logic [3:0] OP_BKSP   = 4'd2;
  localparam logic [3:0] OP_DEL    = 4'd3;
  localparam logic [3:0] OP_LEFT   = 4'd4;
  localparam logic [3:0] OP_RIGHT  = 4'd5;
  localparam logic [3:0] OP_HOME   = 4'd6;
  localparam logic [3:0] OP_END    = 4'd7;
  localparam logic [3:0] OP_CLEAR  = 4'd8;
  localparam logic [3:0] OP_READ   = 4'd9;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic               consumed;
    logic [FIELD_W-1:0] text_length;
    logic [FIELD_W-1:0] cursor_pos;
    logic [FIELD_W-1:0] char_out;
    logic               char_valid;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]         op;
    logic [FIELD_W-1:0] ch;
  } op_item_t;

endpackage

`default_nettype wire

### rtl/leb_front.sv
`default_nettype none

module leb_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire leb_pkg::in_item_t  in_data,
  output logic                    q_valid,
  input  wire logic               q_pop,
  output leb_pkg::op_item_t       q_item
);

  leb_pkg::op_item_t slot_r [2];
  leb_pkg::op_item_t cls_item;
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              push;
  logic              pop;

  // Classify the keystroke; a refused code or an unused command becomes a no-op.
  always_comb begin
    cls_item.ch = in_data.char_code[leb_pkg::FIELD_W-1:0];
    case (in_data.command)
      leb_pkg::CMD_TYPE: begin
        if (in_data.char_code >= leb_pkg::CHAR_LOW && in_data.char_code <= leb_pkg::CHAR_HIGH) begin
          cls_item.op = leb_pkg::OP_INSERT;
        end else begin
          cls_item.op = leb_pkg::OP_NOP;
        end
      end
      leb_pkg::CMD_BKSP:  cls_item.op = leb_pkg::OP_BKSP;
      leb_pkg::CMD_DEL:   cls_item.op = leb_pkg::OP_DEL;
      leb_pkg::CMD_LEFT:  cls_item.op = leb_pkg::OP_LEFT;
      leb_pkg::CMD_RIGHT: cls_item.op = leb_pkg::OP_RIGHT;
      leb_pkg::CMD_HOME:  cls_item.op = leb_pkg::OP_HOME;
      leb_pkg::CMD_END:   cls_item.op = leb_pkg::OP_END;
      leb_pkg::CMD_CLEAR: cls_item.op = leb_pkg::OP_CLEAR;
      leb_pkg::CMD_READ:  cls_item.op = leb_pkg::OP_READ;
      default:            cls_item.op = leb_pkg::OP_NOP;
    endcase
  end

  // Two-entry queue toward the editing engine.
  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue slots hold payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

### rtl/leb_back.sv
`default_nettype none

module leb_back #(
  parameter int MAX_LEN = leb_pkg::MAX_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [leb_pkg::FIELD_W-1:0]  cfg_wdata,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire leb_pkg::op_item_t            q_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output leb_pkg::out_item_t                out_data
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CMP_W = (LEN_W > leb_pkg::FIELD_W) ? LEN_W : leb_pkg::FIELD_W;
  localparam int FW    = leb_pkg::FIELD_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SHIFT   = 3'd1;
  localparam logic [2:0] ST_PUT     = 3'd2;
  localparam logic [2:0] ST_RD_REQ  = 3'd3;
  localparam logic [2:0] ST_RD_EMIT = 3'd4;
  localparam logic [2:0] ST_RESULT  = 3'd5;

  logic [FW-1:0]      mem [MAX_LEN];
  logic [FW-1:0]      rd_data_r;

  logic [2:0]         state_r, state_nxt;
  logic [LEN_W-1:0]   length_r, length_nxt;
  logic [LEN_W-1:0]   cursor_r, cursor_nxt;
  logic [FW-1:0]      max_chars_r, max_chars_nxt;
  logic [LEN_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [LEN_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [LEN_W-1:0]   rd_left_r, rd_left_nxt;
  logic               pend_r, pend_nxt;
  logic               up_r, up_nxt;
  logic [FW-1:0]      ch_r, ch_nxt;
  logic               consumed_r, consumed_nxt;
  logic               out_valid_r, out_valid_nxt;
  leb_pkg::out_item_t out_data_r, out_data_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [FW-1:0]      mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  logic [CMP_W-1:0]   cap;
  logic               can_insert;
  logic               out_free;
  logic               rd_last;

  // Effective capacity is the register saturated to the store depth.
  assign cap = (CMP_W'(max_chars_r) > CMP_W'(MAX_LEN)) ? CMP_W'(MAX_LEN) : CMP_W'(max_chars_r);
  assign can_insert = CMP_W'(length_r) < cap;
  assign out_free   = !out_valid_r || out_ready;
  assign rd_last    = (rd_idx_r == length_r - LEN_W'(1));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Editing sequencer: starts an operation, shifts the store one entry a cycle, reports.
  always_comb begin
    state_nxt     = state_r;
    length_nxt    = length_r;
    cursor_nxt    = cursor_r;
    max_chars_nxt = cfg_we ? cfg_wdata : max_chars_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    rd_left_nxt   = rd_left_r;
    pend_nxt      = pend_r;
    up_nxt        = up_r;
    ch_nxt        = ch_r;
    consumed_nxt  = consumed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wr_idx_r[AW-1:0];
    mem_wdata     = rd_data_r;
    mem_re        = 1'b0;
    mem_raddr     = rd_idx_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          consumed_nxt = 1'b0;
          pend_nxt     = 1'b0;
          state_nxt    = ST_RESULT;
          case (q_item.op)
            leb_pkg::OP_INSERT: begin
              if (can_insert) begin
                consumed_nxt = 1'b1;
                up_nxt       = 1'b1;
                ch_nxt       = q_item.ch;
                rd_idx_nxt   = length_r - LEN_W'(1);
                wr_idx_nxt   = length_r;
                rd_left_nxt  = length_r - cursor_r;
                length_nxt   = length_r + LEN_W'(1);
                cursor_nxt   = cursor_r + LEN_W'(1);
                state_nxt    = ST_SHIFT;
              end
            end
            leb_pkg::OP_BKSP: begin
              if (length_r != '0 && cursor_r != '0) begin
                up_nxt      = 1'b0;
                wr_idx_nxt  = cursor_r - LEN_W'(1);
                rd_idx_nxt  = cursor_r;
                rd_left_nxt = length_r - cursor_r;
                cursor_nxt  = cursor_r - LEN_W'(1);
                length_nxt  = length_r - LEN_W'(1);
                state_nxt   = ST_SHIFT;
              end
            end
            leb_pkg::OP_DEL: begin
              if (length_r != '0 && cursor_r < length_r) begin
                up_nxt      = 1'b0;
                wr_idx_nxt  = cursor_r;
                rd_idx_nxt  = cursor_r + LEN_W'(1);
                rd_left_nxt = length_r - cursor_r - LEN_W'(1);
                length_nxt  = length_r - LEN_W'(1);
                state_nxt   = ST_SHIFT;
              end
            end
            leb_pkg::OP_LEFT: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - LEN_W'(1);
              end
            end
            leb_pkg::OP_RIGHT: begin
              if (cursor_r < length_r) begin
                cursor_nxt = cursor_r + LEN_W'(1);
              end
            end
            leb_pkg::OP_HOME: cursor_nxt = '0;
            leb_pkg::OP_END:  cursor_nxt = length_r;
            leb_pkg::OP_CLEAR: begin
              length_nxt = '0;
              cursor_nxt = '0;
            end
            leb_pkg::OP_READ: begin
              if (length_r != '0) begin
                rd_idx_nxt = '0;
                state_nxt  = ST_RD_REQ;
              end
            end
            default: state_nxt = ST_RESULT;
          endcase
        end
      end

      ST_SHIFT: begin
        // Write the entry read in the previous cycle while reading the next one.
        if (pend_r) begin
          mem_we     = 1'b1;
          wr_idx_nxt = up_r ? wr_idx_r - LEN_W'(1) : wr_idx_r + LEN_W'(1);
        end
        if (rd_left_r != '0) begin
          mem_re      = 1'b1;
          rd_idx_nxt  = up_r ? rd_idx_r - LEN_W'(1) : rd_idx_r + LEN_W'(1);
          rd_left_nxt = rd_left_r - LEN_W'(1);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = up_r ? ST_PUT : ST_RESULT;
          end
        end
      end

      ST_PUT: begin
        // The gap left by the shift is now at the old cursor.
        mem_we    = 1'b1;
        mem_wdata = ch_r;
        state_nxt = ST_RESULT;
      end

      ST_RD_REQ: begin
        mem_re    = 1'b1;
        state_nxt = ST_RD_EMIT;
      end

      ST_RD_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.consumed   = 1'b0;
          out_data_nxt.text_length = FW'(length_r);
          out_data_nxt.cursor_pos = FW'(cursor_r);
          out_data_nxt.char_out   = rd_data_r;
          out_data_nxt.char_valid = 1'b1;
          out_data_nxt.last       = rd_last;
          rd_idx_nxt              = rd_idx_r + LEN_W'(1);
          state_nxt               = rd_last ? ST_IDLE : ST_RD_REQ;
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.consumed    = consumed_r;
          out_data_nxt.text_length = FW'(length_r);
          out_data_nxt.cursor_pos  = FW'(cursor_r);
          out_data_nxt.char_out    = '0;
          out_data_nxt.char_valid  = 1'b0;
          out_data_nxt.last        = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      length_r    <= '0;
      cursor_r    <= '0;
      max_chars_r <= leb_pkg::MAX_CHARS_RST;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      length_r    <= length_nxt;
      cursor_r    <= cursor_nxt;
      max_chars_r <= max_chars_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers that carry payload only.
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    rd_left_r  <= rd_left_nxt;
    up_r       <= up_nxt;
    ch_r       <= ch_nxt;
    consumed_r <= consumed_nxt;
    out_data_r <= out_data_nxt;
  end

  // Character store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/line_editor_buffer.sv
// Single-line text editor driven by keystroke items.
// Input channel (in_valid/in_ready/in_data) takes one command and key code per item.
// Result channel (out_valid/out_ready/out_data) returns one item per command, or one
// item per stored character for a read, the final one flagged by last.
// cfg_we/cfg_wdata write the capacity register (max_chars) with no wait; write it only
// while the block is idle.
// A cursor, clear, refused or unused command, or a read of an empty line, is taken
// from the queue in the idle state and reported through the result state and the
// output register. Type, backspace and delete shift the store one entry per cycle
// through its single read and write port; type then writes its character in the put
// state. A read of a non-empty line alternates the read request and emit states,
// presenting one character from each emit state.
// The engine works on one item at a time and takes the next from the queue only when
// idle. A two-entry queue sits between the decoder and the editing engine, so
// up to two further items are accepted while an edit is still in progress.
// Reset clears the text length and cursor and sets the capacity to 64; the store itself
// is not cleared, since only written entries are ever read.
// When the receiver stalls, the result waits in the output register, the engine holds,
// and the input side stops accepting once the queue is full.
`default_nettype none

module line_editor_buffer #(
  parameter int MAX_LEN = leb_pkg::MAX_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire leb_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output leb_pkg::out_item_t                out_data,
  input  wire logic                         cfg_we,
  input  wire logic [leb_pkg::FIELD_W-1:0]  cfg_wdata
);

  logic              q_valid;
  logic              q_pop;
  leb_pkg::op_item_t q_item;

  // Decoder and command queue.
  leb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // Editing engine with the character store.
  leb_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/sv/tb_line_editor_buffer.sv
`timescale 1ns / 100ps

module tb_line_editor_buffer;

  // Codes the block must ignore, and a few keys used by the directed part.
  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
  localparam logic [7:0] KEY_A         = 8'd65;
  localparam logic [7:0] KEY_B         = 8'd66;
  localparam logic [7:0] KEY_TOP       = 8'd255;
  localparam int         LONG_HOLD     = 300;
  localparam int         QUIET_LIMIT   = 4000;
  localparam int         FILL_KEYS     = 70;
  localparam int         PHASE_KEYS    = 17;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  leb_pkg::in_item_t           in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  leb_pkg::out_item_t          out_data;
  logic                        cfg_we = 1'b0;
  logic [leb_pkg::FIELD_W-1:0] cfg_wdata = '0;

  // Keystrokes waiting to be sent, and the editor reports they should produce.
  leb_pkg::in_item_t  keystrokes_q[$];
  leb_pkg::out_item_t line_reports_q[$];

  // Shadow copy of the editor state.
  logic [leb_pkg::FIELD_W-1:0] ed_text [leb_pkg::MAX_LEN_DEF];
  int                          ed_len = 0;
  int                          ed_cursor = 0;
  logic [leb_pkg::FIELD_W-1:0] ed_limit = leb_pkg::MAX_CHARS_RST;

  int   err_count = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   holds_asked = 0;
  int   holds_done = 0;
  int   quiet_cycles = 0;
  logic idle_on = 1'b1;

  line_editor_buffer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic leb_pkg::out_item_t make_report(logic took,
                                                     logic [leb_pkg::FIELD_W-1:0] ch,
                                                     logic ch_ok, logic fin);
    leb_pkg::out_item_t r;
    r.consumed    = took;
    r.text_length = leb_pkg::FIELD_W'(ed_len);
    r.cursor_pos  = leb_pkg::FIELD_W'(ed_cursor);
    r.char_out    = ch;
    r.char_valid  = ch_ok;
    r.last        = fin;
    return r;
  endfunction

  // Apply one keystroke to the shadow editor and queue the reports it causes.
  task automatic apply_keystroke(leb_pkg::in_item_t k);
    int  room;
    int  i;
    logic took;
    room = (ed_limit > leb_pkg::MAX_LEN_DEF) ? leb_pkg::MAX_LEN_DEF : int'(ed_limit);
    took = 1'b0;
    if (ed_cursor > ed_len) ed_cursor = ed_len;
    if (k.command == leb_pkg::CMD_READ) begin
      if (ed_len == 0) begin
        line_reports_q.push_back(make_report(1'b0, '0, 1'b0, 1'b1));
      end else begin
        for (i = 0; i < ed_len; i++) begin
          line_reports_q.push_back(make_report(1'b0, ed_text[i], 1'b1, i + 1 == ed_len));
        end
      end
    end else begin
      case (k.command)
        leb_pkg::CMD_TYPE: begin
          if (ed_len < room && k.char_code >= leb_pkg::CHAR_LOW &&
              k.char_code <= leb_pkg::CHAR_HIGH) begin
            for (i = ed_len; i > ed_cursor; i--) ed_text[i] = ed_text[i - 1];
            ed_text[ed_cursor] = k.char_code[leb_pkg::FIELD_W-1:0];
            ed_len++;
            ed_cursor++;
            took = 1'b1;
          end
        end
        leb_pkg::CMD_BKSP: begin
          if (ed_len != 0 && ed_cursor != 0) begin
            ed_cursor--;
            for (i = ed_cursor; i + 1 < ed_len; i++) ed_text[i] = ed_text[i + 1];
            ed_len--;
          end
        end
        leb_pkg::CMD_DEL: begin
          if (ed_len != 0 && ed_cursor < ed_len) begin
            for (i = ed_cursor; i + 1 < ed_len; i++) ed_text[i] = ed_text[i + 1];
            ed_len--;
          end
        end
        leb_pkg::CMD_LEFT: begin
          if (ed_cursor > 0) ed_cursor--;
        end
        leb_pkg::CMD_RIGHT: begin
          if (ed_cursor < ed_len) ed_cursor++;
        end
        leb_pkg::CMD_HOME: ed_cursor = 0;
        leb_pkg::CMD_END: ed_cursor = ed_len;
        leb_pkg::CMD_CLEAR: begin
          ed_len = 0;
          ed_cursor = 0;
        end
        default: ;
      endcase
      line_reports_q.push_back(make_report(took, '0, 1'b0, 1'b1));
    end
  endtask

  task automatic flag_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // Compare one received report with the oldest one predicted.
  task automatic check_report(leb_pkg::out_item_t got);
    leb_pkg::out_item_t want;
    if (line_reports_q.size() == 0) begin
      flag_mismatch($sformatf("report with nothing pending: %h", got));
    end else begin
      want = line_reports_q.pop_front();
      if (got.consumed !== want.consumed)
        flag_mismatch($sformatf("consumed %b, want %b", got.consumed, want.consumed));
      if (got.text_length !== want.text_length)
        flag_mismatch($sformatf("text_length %0d, want %0d", got.text_length,
                                want.text_length));
      if (got.cursor_pos !== want.cursor_pos)
        flag_mismatch($sformatf("cursor_pos %0d, want %0d", got.cursor_pos,
                                want.cursor_pos));
      if (got.char_out !== want.char_out)
        flag_mismatch($sformatf("char_out %h, want %h", got.char_out, want.char_out));
      if (got.char_valid !== want.char_valid)
        flag_mismatch($sformatf("char_valid %b, want %b", got.char_valid, want.char_valid));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
    end
  endtask

  // Keystroke driver: an item is predicted at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) apply_keystroke(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (keystrokes_q.size() != 0) begin
          in_data  <= keystrokes_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor with random back-pressure and the occasional long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) check_report(out_data);
      if (holds_done != holds_asked) begin
        holds_done <= holds_done + 1;
        stall_left <= LONG_HOLD;
        out_ready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left <= pick_gap();
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic push_key(logic [3:0] cmd, logic [7:0] code);
    leb_pkg::in_item_t k;
    k.command   = cmd;
    k.char_code = code;
    keystrokes_q.push_back(k);
  endtask

  // Random keystrokes, weighted toward typing printable characters.
  task automatic queue_random(int n);
    int roll;
    int j;
    logic [7:0] code;
    for (j = 0; j < n; j++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 6) == 0) code = 8'($urandom_range(0, 255));
      else code = 8'($urandom_range(leb_pkg::CHAR_LOW, leb_pkg::CHAR_HIGH));
      if (roll < 45) push_key(leb_pkg::CMD_TYPE, code);
      else if (roll < 53) push_key(leb_pkg::CMD_BKSP, code);
      else if (roll < 61) push_key(leb_pkg::CMD_DEL, code);
      else if (roll < 69) push_key(leb_pkg::CMD_LEFT, code);
      else if (roll < 77) push_key(leb_pkg::CMD_RIGHT, code);
      else if (roll < 82) push_key(leb_pkg::CMD_HOME, code);
      else if (roll < 87) push_key(leb_pkg::CMD_END, code);
      else if (roll < 90) push_key(leb_pkg::CMD_CLEAR, code);
      else if (roll < 96) push_key(leb_pkg::CMD_READ, code);
      else push_key(4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), code);
    end
  endtask

  // Wait until every keystroke is sent and every report has come back.
  task automatic wait_drained();
    @(posedge clk);
    while (keystrokes_q.size() != 0 || in_valid || line_reports_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_limit(logic [leb_pkg::FIELD_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    ed_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [leb_pkg::FIELD_W-1:0] limits [8];
    int p;
    int j;
    limits = '{7'd127, 7'd12, 7'd0, 7'd1, 7'd40, 7'd100, 7'd3, 7'd64};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-line corner cases, refused codes, the printable edges and cursor moves.
    push_key(leb_pkg::CMD_READ, 8'd0);
    push_key(leb_pkg::CMD_BKSP, 8'd0);
    push_key(leb_pkg::CMD_DEL, 8'd0);
    push_key(leb_pkg::CMD_LEFT, 8'd0);
    push_key(leb_pkg::CMD_RIGHT, 8'd0);
    push_key(leb_pkg::CMD_TYPE, leb_pkg::CHAR_LOW - 8'd1);
    push_key(leb_pkg::CMD_TYPE, leb_pkg::CHAR_HIGH + 8'd1);
    push_key(leb_pkg::CMD_TYPE, KEY_TOP);
    push_key(leb_pkg::CMD_TYPE, leb_pkg::CHAR_LOW);
    push_key(leb_pkg::CMD_TYPE, leb_pkg::CHAR_HIGH);
    push_key(leb_pkg::CMD_TYPE, KEY_A);
    push_key(leb_pkg::CMD_LEFT, 8'd0);
    push_key(leb_pkg::CMD_LEFT, 8'd0);
    push_key(leb_pkg::CMD_TYPE, KEY_B);
    push_key(leb_pkg::CMD_END, 8'd0);
    push_key(leb_pkg::CMD_RIGHT, 8'd0);
    push_key(leb_pkg::CMD_DEL, 8'd0);
    push_key(leb_pkg::CMD_HOME, 8'd0);
    push_key(leb_pkg::CMD_BKSP, 8'd0);
    push_key(leb_pkg::CMD_DEL, 8'd0);
    push_key(leb_pkg::CMD_READ, 8'd0);
    push_key(CMD_UNUSED_LO, KEY_TOP);
    push_key(CMD_UNUSED_HI, 8'd0);
    push_key(leb_pkg::CMD_CLEAR, 8'd0);
    push_key(leb_pkg::CMD_READ, 8'd0);
    wait_drained();

    for (p = 0; p < 8; p++) begin
      set_limit(limits[p]);
      idle_on = ($urandom_range(0, 3) != 0);
      if (p == 0) begin
        // Fill past the capacity while the receiver holds off, then read it all.
        holds_asked++;
        for (j = 0; j < FILL_KEYS; j++)
          push_key(leb_pkg::CMD_TYPE,
                   8'($urandom_range(leb_pkg::CHAR_LOW, leb_pkg::CHAR_HIGH)));
        push_key(leb_pkg::CMD_READ, 8'd0);
      end else if (p == 1) begin
        // The capacity may now sit below the length, and then typing must be refused.
        push_key(leb_pkg::CMD_TYPE, KEY_A);
        push_key(leb_pkg::CMD_HOME, 8'd0);
        push_key(leb_pkg::CMD_TYPE, KEY_B);
        push_key(leb_pkg::CMD_READ, 8'd0);
      end
      queue_random(PHASE_KEYS);
      wait_drained();
      queue_random(PHASE_KEYS);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/leb_pkg.sv
rtl/leb_front.sv
rtl/leb_back.sv
rtl/line_editor_buffer.sv
tb/sv/tb_line_editor_buffer.sv
